// ----- rtl/scre_pkg.sv -----
// shared types and constants for the slot cache reserve/evict block
// no dependencies

package scre_pkg;

    localparam int TAG_W   = 18;
    localparam int STAMP_W = 64;
    localparam int SLOT_W  = 6;
    localparam int CFG_W   = 7;
    localparam int RES_W   = 3;
    localparam int OP_W    = 2;
    localparam int LAYER_W = 8;
    localparam int EXPERT_W = 10;

    localparam logic [CFG_W-1:0] ACTIVE_RESET = 7'd64;

    localparam logic [OP_W-1:0] OP_REQUEST = 2'd0;
    localparam logic [OP_W-1:0] OP_FILL    = 2'd1;
    localparam logic [OP_W-1:0] OP_PIN     = 2'd2;

    localparam logic [1:0] ST_EMPTY    = 2'd0;
    localparam logic [1:0] ST_INFLIGHT = 2'd1;
    localparam logic [1:0] ST_VALID    = 2'd2;

    localparam logic [RES_W-1:0] RES_HIT       = 3'd0;
    localparam logic [RES_W-1:0] RES_RESERVED  = 3'd1;
    localparam logic [RES_W-1:0] RES_DROPPED   = 3'd2;
    localparam logic [RES_W-1:0] RES_PUBLISHED = 3'd3;
    localparam logic [RES_W-1:0] RES_FREED     = 3'd4;
    localparam logic [RES_W-1:0] RES_PINNED    = 3'd5;
    localparam logic [RES_W-1:0] RES_IGNORED   = 3'd6;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_ADDR,
        S_FINISH
    } t_state;

    typedef struct packed {
        logic clear;
        logic start;
        logic scan;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic clear_last;
        logic scan_done;
        logic out_free;
    } t_sts;

endpackage

// ----- rtl/scre_ctrl.sv -----
// controller state machine: clearing pass, request scan, event update, result hand-off
// depends on scre_pkg

module scre_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic          i_is_request,
    input  scre_pkg::t_sts i_sts,
    output logic          o_in_stall,
    output scre_pkg::t_cmd o_cmd
);

    scre_pkg::t_state r_state;
    scre_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= scre_pkg::S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_stall = 1'b1;
        case (r_state)
            scre_pkg::S_CLEAR: begin
                o_cmd.clear = 1'b1;
                if (i_sts.clear_last) begin
                    n_state = scre_pkg::S_IDLE;
                end
            end
            scre_pkg::S_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.start = 1'b1;
                    n_state = i_is_request ? scre_pkg::S_SCAN : scre_pkg::S_ADDR;
                end
            end
            scre_pkg::S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_sts.scan_done) begin
                    n_state = scre_pkg::S_FINISH;
                end
            end
            scre_pkg::S_ADDR: begin
                n_state = scre_pkg::S_FINISH;
            end
            scre_pkg::S_FINISH: begin
                if (i_sts.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state = scre_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = scre_pkg::S_CLEAR;
            end
        endcase
    end

`ifndef SYNTHESIS
    a_finish_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.finish |-> i_sts.out_free)
        else $error("result written while output busy");
    a_finish_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == scre_pkg::S_FINISH) && i_sts.out_free |=> r_state == scre_pkg::S_IDLE)
        else $error("finish did not return to idle");
    a_start_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.start |=> (r_state == scre_pkg::S_SCAN) || (r_state == scre_pkg::S_ADDR))
        else $error("accepted request did not start work");
`endif

endmodule

// ----- rtl/scre_dp.sv -----
// datapath: slot memories, scan pipeline with match and victim trackers, output register
// depends on scre_pkg

module scre_dp #(
    parameter int NUM_SLOTS = 64
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  scre_pkg::t_cmd                 i_cmd,
    output scre_pkg::t_sts                 o_sts,
    input  logic [scre_pkg::CFG_W-1:0]     i_active_slots,
    input  logic [scre_pkg::OP_W-1:0]      i_operation,
    input  logic [scre_pkg::LAYER_W-1:0]   i_layer,
    input  logic [scre_pkg::EXPERT_W-1:0]  i_expert,
    input  logic [scre_pkg::SLOT_W-1:0]    i_slot_number,
    input  logic                           i_fill_ok,
    input  logic                           i_pin_value,
    input  logic                           i_out_stall,
    output logic                           o_out_valid,
    output logic [scre_pkg::RES_W-1:0]     o_status,
    output logic [scre_pkg::SLOT_W-1:0]    o_slot_index
);

    localparam int SW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int LW = $clog2(NUM_SLOTS + 1);
    localparam int CW = (LW > scre_pkg::CFG_W) ? LW : scre_pkg::CFG_W;

    logic [scre_pkg::TAG_W-1:0]   tag_mem   [NUM_SLOTS];
    logic [scre_pkg::STAMP_W-1:0] stamp_mem [NUM_SLOTS];
    logic [1:0]                   status_mem[NUM_SLOTS];
    logic                         pin_mem   [NUM_SLOTS];

    logic [scre_pkg::OP_W-1:0]    r_op;
    logic [scre_pkg::TAG_W-1:0]   r_tag;
    logic [scre_pkg::SLOT_W-1:0]  r_slot;
    logic                         r_ok;
    logic                         r_pin;

    logic [CW-1:0]                r_addr;
    logic                         r_ev_valid;
    logic [SW-1:0]                r_ev_idx;
    logic [scre_pkg::TAG_W-1:0]   r_rd_tag;
    logic [scre_pkg::STAMP_W-1:0] r_rd_stamp;
    logic [1:0]                   r_rd_status;
    logic                         r_rd_pin;

    logic                         r_have_hit;
    logic                         r_have_empty;
    logic                         r_have_old;
    logic [SW-1:0]                r_hit_idx;
    logic [SW-1:0]                r_empty_idx;
    logic [SW-1:0]                r_old_idx;
    logic [scre_pkg::STAMP_W-1:0] r_oldest;
    logic [scre_pkg::STAMP_W-1:0] r_fill_cnt;

    logic                         r_out_valid;
    logic [scre_pkg::RES_W-1:0]   r_out_status;
    logic [scre_pkg::SLOT_W-1:0]  r_out_slot;

    logic [CW-1:0]                live_n;
    logic [CW-1:0]                slot_ext;
    logic [SW-1:0]                slot_addr;
    logic                         slot_in_range;
    logic                         issue;
    logic [SW-1:0]                rd_addr;
    logic [scre_pkg::STAMP_W-1:0] next_stamp;

    logic                         ev_hit;
    logic                         ev_empty;
    logic                         ev_old;

    logic [scre_pkg::RES_W-1:0]   res_status;
    logic [SW-1:0]                res_idx;
    logic                         res_use_idx;
    logic [scre_pkg::SLOT_W-1:0]  res_slot;
    logic [CW-1:0]                res_idx_ext;
    logic                         st_we;
    logic [SW-1:0]                st_wa;
    logic [1:0]                   st_wd;
    logic                         pin_we;
    logic [SW-1:0]                pin_wa;
    logic                         pin_wd;
    logic                         pub_we;

    assign live_n = (CW'(i_active_slots) > CW'(NUM_SLOTS)) ? CW'(NUM_SLOTS)
                                                         : CW'(i_active_slots);
    assign slot_ext      = CW'(r_slot);
    assign slot_addr     = slot_ext[SW-1:0];
    assign slot_in_range = slot_ext < live_n;
    assign issue         = i_cmd.scan && (r_addr < live_n);
    assign rd_addr       = issue ? r_addr[SW-1:0] : slot_addr;
    assign next_stamp    = r_fill_cnt + 64'd1;

    assign o_sts.clear_last = r_addr == CW'(NUM_SLOTS - 1);
    assign o_sts.scan_done  = !issue && !r_ev_valid;
    assign o_sts.out_free   = !r_out_valid || !i_out_stall;

    assign ev_hit   = r_ev_valid && (r_rd_status == scre_pkg::ST_VALID) && (r_rd_tag == r_tag);
    assign ev_empty = r_ev_valid && (r_rd_status == scre_pkg::ST_EMPTY);
    assign ev_old   = r_ev_valid && (r_rd_status == scre_pkg::ST_VALID) && !r_rd_pin
                      && (!r_have_old || (r_rd_stamp < r_oldest));

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_op   <= i_operation;
            r_tag  <= {i_layer, i_expert};
            r_slot <= i_slot_number;
            r_ok   <= i_fill_ok;
            r_pin  <= i_pin_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_addr     <= '0;
            r_ev_valid <= 1'b0;
        end else begin
            r_ev_valid <= issue;
            if (i_cmd.clear || issue) begin
                r_addr <= r_addr + CW'(1);
            end else if (i_cmd.start) begin
                r_addr <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_ev_idx    <= rd_addr;
        r_rd_tag    <= tag_mem[rd_addr];
        r_rd_stamp  <= stamp_mem[rd_addr];
        r_rd_status <= status_mem[rd_addr];
        r_rd_pin    <= pin_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (st_we) begin
            status_mem[st_wa] <= st_wd;
        end
        if (pin_we) begin
            pin_mem[pin_wa] <= pin_wd;
        end
        if (pub_we) begin
            tag_mem[slot_addr]   <= r_tag;
            stamp_mem[slot_addr] <= next_stamp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have_hit   <= 1'b0;
            r_have_empty <= 1'b0;
            r_have_old   <= 1'b0;
        end else if (i_cmd.start) begin
            r_have_hit   <= 1'b0;
            r_have_empty <= 1'b0;
            r_have_old   <= 1'b0;
        end else begin
            if (ev_hit && !r_have_hit) begin
                r_have_hit <= 1'b1;
            end
            if (ev_empty && !r_have_empty) begin
                r_have_empty <= 1'b1;
            end
            if (ev_old) begin
                r_have_old <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (ev_hit && !r_have_hit) begin
            r_hit_idx <= r_ev_idx;
        end
        if (ev_empty && !r_have_empty) begin
            r_empty_idx <= r_ev_idx;
        end
        if (ev_old) begin
            r_old_idx <= r_ev_idx;
            r_oldest  <= r_rd_stamp;
        end
    end

    always_comb begin
        res_status  = scre_pkg::RES_IGNORED;
        res_idx     = slot_addr;
        res_use_idx = 1'b0;
        st_we       = 1'b0;
        st_wa       = slot_addr;
        st_wd       = scre_pkg::ST_EMPTY;
        pin_we      = 1'b0;
        pin_wa      = slot_addr;
        pin_wd      = r_pin;
        pub_we      = 1'b0;
        case (r_op)
            scre_pkg::OP_REQUEST: begin
                res_use_idx = 1'b1;
                if (r_have_hit) begin
                    res_status = scre_pkg::RES_HIT;
                    res_idx    = r_hit_idx;
                end else if (r_have_empty || r_have_old) begin
                    res_status = scre_pkg::RES_RESERVED;
                    res_idx    = r_have_empty ? r_empty_idx : r_old_idx;
                    st_we      = i_cmd.finish;
                    st_wa      = res_idx;
                    st_wd      = scre_pkg::ST_INFLIGHT;
                end else begin
                    res_status  = scre_pkg::RES_DROPPED;
                    res_use_idx = 1'b0;
                end
            end
            scre_pkg::OP_FILL: begin
                if (slot_in_range && (r_rd_status == scre_pkg::ST_INFLIGHT)) begin
                    st_we = i_cmd.finish;
                    if (r_ok) begin
                        res_status = scre_pkg::RES_PUBLISHED;
                        st_wd      = scre_pkg::ST_VALID;
                        pub_we     = i_cmd.finish;
                    end else begin
                        res_status = scre_pkg::RES_FREED;
                    end
                end
            end
            scre_pkg::OP_PIN: begin
                if (slot_in_range) begin
                    res_status = scre_pkg::RES_PINNED;
                    pin_we     = i_cmd.finish;
                end
            end
            default: begin
                res_status = scre_pkg::RES_IGNORED;
            end
        endcase
        if (i_cmd.clear) begin
            st_we  = 1'b1;
            st_wa  = r_addr[SW-1:0];
            st_wd  = scre_pkg::ST_EMPTY;
            pin_we = 1'b1;
            pin_wa = r_addr[SW-1:0];
            pin_wd = 1'b0;
        end
    end

    assign res_idx_ext = CW'(res_idx);

    always_comb begin
        if (res_use_idx) begin
            res_slot = res_idx_ext[scre_pkg::SLOT_W-1:0];
        end else if ((r_op == scre_pkg::OP_FILL) || (r_op == scre_pkg::OP_PIN)) begin
            res_slot = r_slot;
        end else begin
            res_slot = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill_cnt <= '0;
        end else if (pub_we) begin
            r_fill_cnt <= next_stamp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.finish) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_out_status <= res_status;
            r_out_slot   <= res_slot;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_status     = r_out_status;
    assign o_slot_index = r_out_slot;

`ifndef SYNTHESIS
    a_publish_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pub_we |=> r_fill_cnt == $past(r_fill_cnt) + 64'd1)
        else $error("fill counter did not advance on publish");
    a_reserve_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.finish && (res_status == scre_pkg::RES_RESERVED) |-> !r_have_hit)
        else $error("reserved a slot although a hit was found");
    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.scan |-> r_addr <= live_n)
        else $error("scan address ran past live slot count");
`endif

endmodule

// ----- rtl/slot_cache_reserve_evict.sv -----
// top level of the slot cache reserve/evict block: configuration port, controller, datapath
// depends on scre_pkg, scre_ctrl, scre_dp

// Slot table manager for a fetch cache. A request looks up its (layer, expert) pair among
// the live slots and reports a hit, reserves a victim (lowest empty slot, else the unpinned
// valid slot with the oldest fill stamp) or drops; completions publish or free an in-flight
// slot and pin events set a slot's pin. One request at a time is processed: a request
// makes one pass over the live slots at one read per cycle, then passes the read and
// compare stages and the finish state; completion and pin events pass an address read
// state and the finish state. A finished result sits in an output register while the
// next request is accepted; a stalled result holds the next one in the finish state.
// After reset a clearing pass over all NUM_SLOTS slots empties the slot table and no
// request is accepted until it ends. Configuration must be written only while no request
// is in flight; the block does not enforce this. active_slots lies at byte address 0.

module slot_cache_reserve_evict #(
    parameter int NUM_SLOTS = 64
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [2:0]                     paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic [scre_pkg::OP_W-1:0]      i_operation,
    input  logic [scre_pkg::LAYER_W-1:0]   i_layer,
    input  logic [scre_pkg::EXPERT_W-1:0]  i_expert,
    input  logic [scre_pkg::SLOT_W-1:0]    i_slot_number,
    input  logic                           i_fill_ok,
    input  logic                           i_pin_value,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic [scre_pkg::RES_W-1:0]     o_status,
    output logic [scre_pkg::SLOT_W-1:0]    o_slot_index
);

    logic [scre_pkg::CFG_W-1:0] r_active_slots;
    scre_pkg::t_cmd             cmd;
    scre_pkg::t_sts             sts;
    logic                       cfg_sel;

    assign pready  = 1'b1;
    assign cfg_sel = !paddr[2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active_slots <= scre_pkg::ACTIVE_RESET;
        end else if (psel && penable && pwrite && cfg_sel) begin
            r_active_slots <= pwdata[scre_pkg::CFG_W-1:0];
        end
    end

    assign prdata = cfg_sel ? {{(32 - scre_pkg::CFG_W){1'b0}}, r_active_slots} : 32'd0;

    scre_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_is_request (i_operation == scre_pkg::OP_REQUEST),
        .i_sts        (sts),
        .o_in_stall   (o_in_stall),
        .o_cmd        (cmd)
    );

    scre_dp #(
        .NUM_SLOTS (NUM_SLOTS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .i_active_slots (r_active_slots),
        .i_operation    (i_operation),
        .i_layer        (i_layer),
        .i_expert       (i_expert),
        .i_slot_number  (i_slot_number),
        .i_fill_ok      (i_fill_ok),
        .i_pin_value    (i_pin_value),
        .i_out_stall    (i_out_stall),
        .o_out_valid    (o_out_valid),
        .o_status       (o_status),
        .o_slot_index   (o_slot_index)
    );

endmodule

// ----- tb/tb_slot_cache_reserve_evict.sv -----
// self-checking testbench for slot_cache_reserve_evict: directed table, then random phases
// keeps its own model of the slot table and checks every result in order
// depends on scre_pkg and the rtl of slot_cache_reserve_evict

module tb_slot_cache_reserve_evict;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SLOTS = 64;
    localparam int KEYS = 16;
    localparam int PHASES = 8;
    localparam int PHASE_ITEMS = 106;
    localparam int OP_BITS = scre_pkg::OP_W;
    localparam int LAYER_BITS = scre_pkg::LAYER_W;
    localparam int EXPERT_BITS = scre_pkg::EXPERT_W;
    localparam int SLOT_BITS = scre_pkg::SLOT_W;
    localparam logic [2:0] ADDR_ACTIVE = 3'd0;
    localparam logic [scre_pkg::OP_W-1:0] OP_UNUSED = 2'd3;
    localparam bit FIXED = 1'b1;
    localparam bit CALC = 1'b0;

    typedef struct packed {
        logic [scre_pkg::OP_W-1:0]     op;
        logic [scre_pkg::LAYER_W-1:0]  layer;
        logic [scre_pkg::EXPERT_W-1:0] expert;
        logic [scre_pkg::SLOT_W-1:0]   slot;
        logic                          ok;
        logic                          pin;
    } t_req;

    typedef struct packed {
        logic [scre_pkg::RES_W-1:0]  status;
        logic [scre_pkg::SLOT_W-1:0] slot;
    } t_res;

    typedef struct packed {
        bit                         is_cfg;
        logic [scre_pkg::CFG_W-1:0] cfg_val;
        t_req                       req;
        bit                         typed;
        t_res                       res;
    } t_row;

    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          psel = 1'b0;
    logic                          penable = 1'b0;
    logic                          pwrite = 1'b0;
    logic [2:0]                    paddr = '0;
    logic [31:0]                   pwdata = '0;
    logic [31:0]                   prdata;
    logic                          pready;
    logic                          i_in_valid = 1'b0;
    logic                          o_in_stall;
    logic [scre_pkg::OP_W-1:0]     i_operation = '0;
    logic [scre_pkg::LAYER_W-1:0]  i_layer = '0;
    logic [scre_pkg::EXPERT_W-1:0] i_expert = '0;
    logic [scre_pkg::SLOT_W-1:0]   i_slot_number = '0;
    logic                          i_fill_ok = 1'b0;
    logic                          i_pin_value = 1'b0;
    logic                          o_out_valid;
    logic                          i_out_stall = 1'b0;
    logic [scre_pkg::RES_W-1:0]    o_status;
    logic [scre_pkg::SLOT_W-1:0]   o_slot_index;

    // model of the slot table
    logic [scre_pkg::TAG_W-1:0]   slot_tag [SLOTS];
    logic [1:0]                   slot_state [SLOTS];
    logic [scre_pkg::STAMP_W-1:0] slot_stamp [SLOTS];
    logic                         slot_pin [SLOTS];
    logic [scre_pkg::STAMP_W-1:0] fill_count;
    logic [scre_pkg::CFG_W-1:0]   active_cfg;

    logic [scre_pkg::TAG_W-1:0]    reserved_tag [SLOTS];
    logic [scre_pkg::LAYER_W-1:0]  pool_layer [KEYS];
    logic [scre_pkg::EXPERT_W-1:0] pool_expert [KEYS];

    t_res outcome_q [$];
    t_row plan [$];
    t_res want;
    int   mismatches = 0;
    int   send_pct = 0;
    int   recv_pct = 0;

    slot_cache_reserve_evict #(.NUM_SLOTS(SLOTS)) u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_operation   (i_operation),
        .i_layer       (i_layer),
        .i_expert      (i_expert),
        .i_slot_number (i_slot_number),
        .i_fill_ok     (i_fill_ok),
        .i_pin_value   (i_pin_value),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_status      (o_status),
        .o_slot_index  (o_slot_index)
    );

    always #1 i_clk = ~i_clk;

    initial begin
        #2_000_000;
        $display("[slot_cache_reserve_evict] ERROR");
        $finish;
    end

    function automatic int live_slots();
        return (active_cfg > SLOTS) ? SLOTS : int'(active_cfg);
    endfunction

    function automatic t_res predict_outcome(t_req r);
        t_res o;
        int n;
        int hit_at;
        int empty_at;
        int old_at;
        logic [scre_pkg::TAG_W-1:0] key;
        n = live_slots();
        key = {r.layer, r.expert};
        hit_at = -1;
        empty_at = -1;
        old_at = -1;
        o.status = scre_pkg::RES_IGNORED;
        o.slot = '0;
        case (r.op)
            scre_pkg::OP_REQUEST: begin
                for (int i = 0; i < n; i++) begin
                    if (hit_at < 0 && slot_state[i] == scre_pkg::ST_VALID && slot_tag[i] == key)
                        hit_at = i;
                    if (empty_at < 0 && slot_state[i] == scre_pkg::ST_EMPTY)
                        empty_at = i;
                    if (slot_state[i] == scre_pkg::ST_VALID && !slot_pin[i] &&
                        (old_at < 0 || slot_stamp[i] < slot_stamp[old_at]))
                        old_at = i;
                end
                if (hit_at >= 0) begin
                    o.status = scre_pkg::RES_HIT;
                    o.slot = SLOT_BITS'(hit_at);
                end else if (empty_at >= 0 || old_at >= 0) begin
                    o.status = scre_pkg::RES_RESERVED;
                    o.slot = SLOT_BITS'((empty_at >= 0) ? empty_at : old_at);
                    slot_state[o.slot] = scre_pkg::ST_INFLIGHT;
                end else begin
                    o.status = scre_pkg::RES_DROPPED;
                end
            end
            scre_pkg::OP_FILL: begin
                o.slot = r.slot;
                if (r.slot < n && slot_state[r.slot] == scre_pkg::ST_INFLIGHT) begin
                    if (r.ok) begin
                        fill_count = fill_count + 1'b1;
                        slot_tag[r.slot] = key;
                        slot_stamp[r.slot] = fill_count;
                        slot_state[r.slot] = scre_pkg::ST_VALID;
                        o.status = scre_pkg::RES_PUBLISHED;
                    end else begin
                        slot_state[r.slot] = scre_pkg::ST_EMPTY;
                        o.status = scre_pkg::RES_FREED;
                    end
                end
            end
            scre_pkg::OP_PIN: begin
                o.slot = r.slot;
                if (r.slot < n) begin
                    slot_pin[r.slot] = r.pin;
                    o.status = scre_pkg::RES_PINNED;
                end
            end
            default: o.slot = '0;
        endcase
        return o;
    endfunction

    // mostly well-formed traffic: keys from a small pool, fills aimed at in-flight slots
    function automatic t_req gen_req();
        t_req r;
        int n;
        int roll;
        int k;
        int busy [$];
        n = live_slots();
        r.op = scre_pkg::OP_REQUEST;
        r.layer = LAYER_BITS'($urandom);
        r.expert = EXPERT_BITS'($urandom);
        r.slot = SLOT_BITS'($urandom);
        r.ok = 1'($urandom);
        r.pin = 1'($urandom);
        roll = $urandom_range(99);
        k = $urandom_range(KEYS - 1);
        if (roll < 50) begin
            if (roll >= 5) begin
                r.layer = pool_layer[k];
                r.expert = pool_expert[k];
            end
        end else if (roll < 80) begin
            r.op = scre_pkg::OP_FILL;
            for (int i = 0; i < n; i++)
                if (slot_state[i] == scre_pkg::ST_INFLIGHT)
                    busy.push_back(i);
            if (busy.size() != 0) begin
                r.slot = SLOT_BITS'(busy[$urandom_range(busy.size() - 1)]);
                {r.layer, r.expert} = reserved_tag[r.slot];
                r.ok = ($urandom_range(9) != 0);
            end
        end else if (roll < 92) begin
            r.op = scre_pkg::OP_PIN;
            r.slot = SLOT_BITS'($urandom_range(n));
            r.pin = ($urandom_range(2) == 0);
        end else if (roll < 95) begin
            r.op = OP_UNUSED;
        end else begin
            r.op = OP_BITS'($urandom);
        end
        return r;
    endfunction

    function automatic t_row mk_row(logic [scre_pkg::OP_W-1:0] op,
            logic [scre_pkg::LAYER_W-1:0] layer, logic [scre_pkg::EXPERT_W-1:0] expert,
            logic [scre_pkg::SLOT_W-1:0] slot, logic ok, logic pin, bit typed,
            logic [scre_pkg::RES_W-1:0] status, logic [scre_pkg::SLOT_W-1:0] at);
        t_row w;
        w = '0;
        w.req.op = op;
        w.req.layer = layer;
        w.req.expert = expert;
        w.req.slot = slot;
        w.req.ok = ok;
        w.req.pin = pin;
        w.typed = typed;
        w.res.status = status;
        w.res.slot = at;
        return w;
    endfunction

    function automatic t_row cfg_row(logic [scre_pkg::CFG_W-1:0] val);
        t_row w;
        w = '0;
        w.is_cfg = 1'b1;
        w.cfg_val = val;
        return w;
    endfunction

    task automatic send(t_req r, bit typed, t_res fixed);
        t_res got;
        while ($urandom_range(99) < send_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_operation <= r.op;
        i_layer <= r.layer;
        i_expert <= r.expert;
        i_slot_number <= r.slot;
        i_fill_ok <= r.ok;
        i_pin_value <= r.pin;
        do @(posedge i_clk); while (o_in_stall);
        got = predict_outcome(r);
        if (got.status == scre_pkg::RES_RESERVED)
            reserved_tag[got.slot] = {r.layer, r.expert};
        outcome_q.push_back(typed ? fixed : got);
    endtask

    task automatic drain(int extra);
        i_in_valid <= 1'b0;
        while (outcome_q.size() != 0)
            @(posedge i_clk);
        repeat (extra) @(posedge i_clk);
    endtask

    task automatic set_active(logic [scre_pkg::CFG_W-1:0] val);
        drain(4);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= ADDR_ACTIVE;
        pwdata <= {{(32 - scre_pkg::CFG_W){1'b0}}, val};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        active_cfg = val;
    endtask

    // check results in order, and stall the result side at random
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (outcome_q.size() == 0) begin
                $display("%0t: unexpected result status %0d slot %0d", $time, o_status,
                         o_slot_index);
                mismatches++;
            end else begin
                want = outcome_q.pop_front();
                if (o_status !== want.status) begin
                    $display("%0t: status expected %0d got %0d", $time, want.status,
                             o_status);
                    mismatches++;
                end
                if (o_slot_index !== want.slot) begin
                    $display("%0t: slot_index expected %0d got %0d", $time, want.slot,
                             o_slot_index);
                    mismatches++;
                end
            end
        end
        i_out_stall <= ($urandom_range(99) < recv_pct);
    end

    initial begin
        logic [scre_pkg::CFG_W-1:0] phase_active [PHASES];
        phase_active = '{7'd4, 7'd2, 7'd64, 7'd1, 7'd127, 7'd8, 7'd3, 7'd16};
        for (int i = 0; i < SLOTS; i++) begin
            slot_tag[i] = '0;
            slot_state[i] = scre_pkg::ST_EMPTY;
            slot_stamp[i] = '0;
            slot_pin[i] = 1'b0;
            reserved_tag[i] = '0;
        end
        fill_count = '0;
        active_cfg = scre_pkg::ACTIVE_RESET;

        // fresh table, all slots live
        plan.push_back(mk_row(scre_pkg::OP_REQUEST, 8'd0, 10'd0, 6'd0, 1'b0, 1'b0,
                              FIXED, scre_pkg::RES_RESERVED, 6'd0));
        plan.push_back(mk_row(scre_pkg::OP_REQUEST, 8'd255, 10'd1023, 6'd0, 1'b0, 1'b0,
                              FIXED, scre_pkg::RES_RESERVED, 6'd1));
        plan.push_back(mk_row(scre_pkg::OP_FILL, 8'd0, 10'd0, 6'd0, 1'b1, 1'b0,
                              FIXED, scre_pkg::RES_PUBLISHED, 6'd0));
        plan.push_back(mk_row(scre_pkg::OP_FILL, 8'd255, 10'd1023, 6'd1, 1'b0, 1'b0,
                              FIXED, scre_pkg::RES_FREED, 6'd1));
        plan.push_back(mk_row(scre_pkg::OP_REQUEST, 8'd0, 10'd0, 6'd63, 1'b1, 1'b1,
                              FIXED, scre_pkg::RES_HIT, 6'd0));
        plan.push_back(mk_row(scre_pkg::OP_FILL, 8'd7, 10'd9, 6'd5, 1'b1, 1'b0,
                              FIXED, scre_pkg::RES_IGNORED, 6'd5));
        plan.push_back(mk_row(scre_pkg::OP_FILL, 8'd7, 10'd9, 6'd63, 1'b1, 1'b0,
                              FIXED, scre_pkg::RES_IGNORED, 6'd63));
        plan.push_back(mk_row(scre_pkg::OP_PIN, 8'd0, 10'd0, 6'd63, 1'b0, 1'b1,
                              FIXED, scre_pkg::RES_PINNED, 6'd63));
        plan.push_back(mk_row(OP_UNUSED, 8'd255, 10'd1023, 6'd63, 1'b1, 1'b1,
                              FIXED, scre_pkg::RES_IGNORED, 6'd0));
        // a pinned empty slot is still taken
        plan.push_back(mk_row(scre_pkg::OP_PIN, 8'd0, 10'd0, 6'd1, 1'b0, 1'b1,
                              FIXED, scre_pkg::RES_PINNED, 6'd1));
        plan.push_back(mk_row(scre_pkg::OP_REQUEST, 8'd255, 10'd1023, 6'd0, 1'b0, 1'b0,
                              FIXED, scre_pkg::RES_RESERVED, 6'd1));
        plan.push_back(mk_row(scre_pkg::OP_FILL, 8'd255, 10'd1023, 6'd1, 1'b1, 1'b0,
                              FIXED, scre_pkg::RES_PUBLISHED, 6'd1));
        plan.push_back(mk_row(scre_pkg::OP_PIN, 8'd0, 10'd0, 6'd1, 1'b0, 1'b0,
                              FIXED, scre_pkg::RES_PINNED, 6'd1));
        // two live slots: eviction by oldest stamp, drops, out of range events
        plan.push_back(cfg_row(7'd2));
        plan.push_back(mk_row(scre_pkg::OP_REQUEST, 8'd1, 10'd1, 6'd0, 1'b0, 1'b0,
                              CALC, '0, '0));
        plan.push_back(mk_row(scre_pkg::OP_REQUEST, 8'd2, 10'd2, 6'd0, 1'b0, 1'b0,
                              CALC, '0, '0));
        plan.push_back(mk_row(scre_pkg::OP_REQUEST, 8'd3, 10'd3, 6'd0, 1'b0, 1'b0,
                              FIXED, scre_pkg::RES_DROPPED, 6'd0));
        plan.push_back(mk_row(scre_pkg::OP_FILL, 8'd3, 10'd3, 6'd2, 1'b1, 1'b0,
                              FIXED, scre_pkg::RES_IGNORED, 6'd2));
        plan.push_back(mk_row(scre_pkg::OP_PIN, 8'd0, 10'd0, 6'd2, 1'b0, 1'b1,
                              FIXED, scre_pkg::RES_IGNORED, 6'd2));
        plan.push_back(mk_row(scre_pkg::OP_FILL, 8'd1, 10'd1, 6'd0, 1'b1, 1'b0,
                              CALC, '0, '0));
        plan.push_back(mk_row(scre_pkg::OP_FILL, 8'd2, 10'd2, 6'd1, 1'b1, 1'b0,
                              CALC, '0, '0));
        plan.push_back(mk_row(scre_pkg::OP_PIN, 8'd0, 10'd0, 6'd1, 1'b0, 1'b1,
                              CALC, '0, '0));
        plan.push_back(mk_row(scre_pkg::OP_REQUEST, 8'd3, 10'd3, 6'd0, 1'b0, 1'b0,
                              CALC, '0, '0));
        plan.push_back(mk_row(scre_pkg::OP_REQUEST, 8'd4, 10'd4, 6'd0, 1'b0, 1'b0,
                              FIXED, scre_pkg::RES_DROPPED, 6'd0));
        plan.push_back(mk_row(scre_pkg::OP_FILL, 8'd3, 10'd3, 6'd0, 1'b0, 1'b0,
                              CALC, '0, '0));
        // no live slots
        plan.push_back(cfg_row(7'd0));
        plan.push_back(mk_row(scre_pkg::OP_REQUEST, 8'd0, 10'd0, 6'd0, 1'b0, 1'b0,
                              FIXED, scre_pkg::RES_DROPPED, 6'd0));
        plan.push_back(mk_row(scre_pkg::OP_FILL, 8'd0, 10'd0, 6'd0, 1'b1, 1'b0,
                              FIXED, scre_pkg::RES_IGNORED, 6'd0));
        plan.push_back(mk_row(scre_pkg::OP_PIN, 8'd0, 10'd0, 6'd0, 1'b0, 1'b1,
                              FIXED, scre_pkg::RES_IGNORED, 6'd0));
        // count above the table size, hidden slots come back
        plan.push_back(cfg_row(7'd127));
        plan.push_back(mk_row(scre_pkg::OP_REQUEST, 8'd2, 10'd2, 6'd0, 1'b0, 1'b0,
                              CALC, '0, '0));
        plan.push_back(mk_row(scre_pkg::OP_FILL, 8'd2, 10'd2, 6'd1, 1'b1, 1'b0,
                              CALC, '0, '0));

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (plan[i]) begin
            if (plan[i].is_cfg)
                set_active(plan[i].cfg_val);
            else
                send(plan[i].req, plan[i].typed, plan[i].res);
        end

        for (int p = 0; p < PHASES; p++) begin
            set_active(phase_active[p]);
            send_pct = (p % 4 == 1) ? 64 : (p % 4 == 3) ? 21 : 0;
            recv_pct = (p % 4 == 2) ? 64 : (p % 4 == 3) ? 21 : 0;
            for (int k = 0; k < KEYS; k++) begin
                pool_layer[k] = LAYER_BITS'($urandom);
                pool_expert[k] = EXPERT_BITS'($urandom);
            end
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                if (p == 1 && k == PHASE_ITEMS / 2)
                    drain(1);
                send(gen_req(), CALC, '0);
            end
        end

        drain(80);
        if (mismatches == 0)
            $display("[slot_cache_reserve_evict] OK");
        else
            $display("[slot_cache_reserve_evict] ERROR");
        $finish;
    end

endmodule
